### rtl/core/matrix_stack_transform_engine_defines.svh
// Assertion macros shared by the matrix stack engine RTL.
// No dependencies.
`ifndef MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH
`define MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH
// Clocked implication check, disabled in reset.
`define MSTE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check, disabled in reset.
`define MSTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/mste_pkg.sv
// Package for the matrix stack transform engine: sizes, opcodes, fixed-point helpers.
// No dependencies.
package mste_pkg;
  localparam int StackDepth = 16;
  localparam int TopW = 4;
  localparam logic [2:0] OP_LOAD = 3'd0, OP_ADD = 3'd1, OP_POP1 = 3'd2, OP_POPN = 3'd3,
                         OP_DMA = 3'd4, OP_RESET = 3'd5, OP_INSERT = 3'd6, OP_FORCE = 3'd7;
  localparam logic [31:0] FX_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  a_sel;   // 0 staged, 1 modelview entry, 2 projection entry
    logic [1:0]  b_sel;
  } mul_req_t;

  // Round one 32x32 product to 16.16 (floor of (p+0x8000)/65536).
  function automatic logic signed [47:0] fx_round(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p + 64'sh8000;
    return q[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
    if (s > 50'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -50'sh8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic [31:0] ident(input logic [3:0] i);
    return (i == 4'd0 || i == 4'd5 || i == 4'd10 || i == 4'd15) ? FX_ONE : 32'd0;
  endfunction
endpackage

### rtl/core/mste_mac.sv
// Shared multiply-accumulate unit: one signed 32x32 product per cycle,
// registered, then rounded and summed. Depends on mste_pkg.
module mste_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic                en,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic                acc_en,
  output logic signed [31:0]  sum_sat
);
  import mste_pkg::*;
  logic signed [63:0] prod_r;
  logic signed [49:0] acc_r, acc_nxt;
  logic               pv_r;

  // Product register
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n) pv_r <= 1'b0;
    else pv_r <= en;
  end

  // Accumulate the rounded terms
  always_comb begin
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (acc_en && pv_r) acc_nxt = acc_r + 50'(fx_round(prod_r));
  end
  always_ff @(posedge clk) acc_r <= acc_nxt;
  assign sum_sat = sat32(acc_r);
endmodule

### rtl/core/matrix_stack_transform_engine.sv
// Matrix stack transform engine. One command is taken at a time; in_tready
// is low while it runs. A load-element transaction is taken in its accept
// cycle, so loads stream back to back. Commands other than load and force
// use one shared 32x32 multiplier: each element of a 4x4 product is fetched,
// multiplied and accumulated in S_MUL, then written back in S_MULW. Stack
// writes go element by element; every non-load command ends with the emit
// of the combined matrix, and all but force pass through an insert slot
// before it. Pop, insert, add with replace, reset and dma copy compute one
// product; add with multiply and dma with multiply compute two. Output
// stalls add to the emit. Stack entries live in small memories, one read
// port each. After reset a clearing pass of one word per cycle runs before
// the first command is taken. Depends on mste_pkg, mste_mac and the defines
// header.
`include "matrix_stack_transform_engine_defines.svh"
module matrix_stack_transform_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] operation, [6:3] element_index, [22:7] element_high,
  // [38:23] element_low, [39] to_projection, [40] push_first,
  // [41] replace_top, [45:42] stack_index, [46] multiply_first,
  // [52:47] insert_offset, [84:53] argument_word, zero pad to 88
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] combined_value, [35:32] combined_index, zero pad to 40
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  import mste_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MUL = 4'd2, S_MULW = 4'd3,
                         S_COPY = 4'd4, S_COMB = 4'd5, S_INS = 4'd6, S_EMIT = 4'd7,
                         S_IDW = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [87:0] cmd_r;
  logic [31:0] staged_r [16];
  logic [31:0] comb_r [16];
  logic [31:0] mv_mem [StackDepth*16];
  logic [31:0] pj_mem [StackDepth*16];
  logic [31:0] tmp_r [16];
  logic [TopW-1:0] mv_top_r, pj_top_r;
  logic [8:0]  cnt_r;
  logic [1:0]  phase_r;     // 0 first product, 1 recompute product
  logic [2:0]  kk_r;
  logic [3:0]  ee_r;
  logic [31:0] mv_rd_r, pj_rd_r;
  logic [7:0]  mv_ra, pj_ra;
  logic [TopW-1:0] mv_src_r, pj_src_r, dst_r;
  logic        dst_pj_r;
  logic [3:0]  emit_idx_r;
  logic signed [31:0] macs;
  logic        mac_clr, mac_en;
  logic signed [31:0] ma, mb;
  mul_req_t    req;

  wire [2:0]  c_op  = cmd_r[2:0];
  wire        c_prj = cmd_r[39];
  wire [5:0]  c_off = cmd_r[52:47];
  wire [31:0] c_arg = cmd_r[84:53];

  assign in_tready = (state_r == S_IDLE);
  wire acc = in_tvalid && in_tready;

  // Operand selection for the shared unit: element ee, term kk.
  wire [1:0] i_r = ee_r[3:2];
  wire [1:0] j_r = ee_r[1:0];
  wire [3:0] ai = {i_r, kk_r[1:0]};
  wire [3:0] bi = {kk_r[1:0], j_r};
  always_comb begin
    req.a_sel = 2'd0; req.b_sel = 2'd1;
    if (phase_r == 2'd1) begin req.a_sel = 2'd1; req.b_sel = 2'd2; end
    else if (c_op == OP_ADD) begin req.a_sel = 2'd0; req.b_sel = c_prj ? 2'd2 : 2'd1; end
    else begin req.a_sel = 2'd1; req.b_sel = 2'd0; end
    mv_ra = {mv_src_r, (req.a_sel == 2'd1) ? ai : bi};
    pj_ra = {pj_src_r, bi};
    if (state_r == S_COPY || state_r == S_IDW) begin
      mv_ra = {mv_src_r, ee_r}; pj_ra = {pj_src_r, ee_r};
    end
  end
  always_ff @(posedge clk) begin
    mv_rd_r <= mv_mem[mv_ra];
    pj_rd_r <= pj_mem[pj_ra];
  end
  // The read data of term kk is registered, ready in the cycle after its address.
  logic [3:0] ad_r, bd_r;
  always_ff @(posedge clk) begin ad_r <= ai; bd_r <= bi; end
  always_comb begin
    ma = (req.a_sel == 2'd0) ? staged_r[ad_r] : mv_rd_r;
    case (req.b_sel)
      2'd0: mb = staged_r[bd_r];
      2'd1: mb = mv_rd_r;
      default: mb = pj_rd_r;
    endcase
  end
  assign mac_clr = (state_r == S_MUL) && (kk_r == 3'd0);
  assign mac_en  = (state_r == S_MUL) && (kk_r >= 3'd1) && (kk_r <= 3'd4);

  mste_mac u_mac (.clk, .rst_n, .clr(mac_clr), .en(mac_en), .a(ma), .b(mb),
                  .acc_en(state_r == S_MUL && kk_r >= 3'd2), .sum_sat(macs));

  // Memory writes
  logic        mv_we, pj_we;
  logic [7:0]  wa;
  logic [31:0] wd;
  always_ff @(posedge clk) begin
    if (mv_we) mv_mem[wa] <= wd;
    if (pj_we) pj_mem[wa] <= wd;
  end

  // Insert helper for one word
  function automatic logic [31:0] ins(input logic [31:0] v, input logic [15:0] h,
                                      input logic lowhalf);
    logic [31:0] mag, nv;
    logic [15:0] ip;
    mag = v[31] ? (32'd0 - v) : v;
    if (!lowhalf) nv = {h, mag[15:0]};
    else begin
      ip = mag[31:16];
      if (v[31]) ip = 16'd0 - ip;
      nv = {ip, h};
      if (ip == 16'd0 && v[31]) nv = 32'd0 - nv;
    end
    return nv;
  endfunction

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mv_we = 1'b0; pj_we = 1'b0;
    wa = {dst_r, ee_r}; wd = tmp_r[ee_r];
    case (state_r)
      S_CLR: begin
        wa = cnt_r[7:0]; wd = (cnt_r[7:4] == 4'd0) ? ident(cnt_r[3:0]) : 32'd0;
        mv_we = 1'b1; pj_we = 1'b1;
        if (cnt_r == 9'd255) state_nxt = S_IDLE;
      end
      S_IDLE: if (acc) begin
        case (in_tdata[2:0])
          OP_LOAD: state_nxt = S_IDLE;
          OP_ADD: state_nxt = in_tdata[41] ? S_COPY : S_MUL;
          OP_POP1, OP_POPN, OP_INSERT: state_nxt = S_COMB;
          OP_DMA: state_nxt = in_tdata[46] ? S_MUL : S_COPY;
          OP_RESET: state_nxt = S_COPY;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_MUL: if (kk_r == 3'd5) state_nxt = S_MULW;
      S_MULW: if (ee_r == 4'd15) state_nxt = (phase_r == 2'd1) ? S_INS : S_COPY;
              else state_nxt = S_MUL;
      S_COPY: begin
        mv_we = !dst_pj_r; pj_we = dst_pj_r;
        if (ee_r == 4'd15) begin
          // reset writes modelview entry zero, then projection entry zero
          if (c_op == OP_RESET && !dst_pj_r) state_nxt = S_COPY;
          else if (c_op == OP_DMA) state_nxt = S_IDW;
          else state_nxt = S_COMB;
        end
      end
      S_IDW: begin
        wa = {pj_top_r, ee_r}; wd = ident(ee_r); pj_we = 1'b1;
        if (ee_r == 4'd15) state_nxt = S_COMB;
      end
      S_COMB: state_nxt = S_MUL;
      S_INS: state_nxt = S_EMIT;
      S_EMIT: if (out_tready && emit_idx_r == 4'd15) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; cnt_r <= '0; mv_top_r <= '0; pj_top_r <= '0;
      emit_idx_r <= '0; phase_r <= '0; kk_r <= '0; ee_r <= '0;
      for (int i = 0; i < 16; i++) begin
        staged_r[i] <= '0; comb_r[i] <= ident(4'(i));
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_r + 9'd1;
      case (state_r)
        S_IDLE: if (acc) begin
          cmd_r <= in_tdata;
          ee_r <= '0; kk_r <= '0; emit_idx_r <= '0;
          // dma multiplies by modelview entry zero
          mv_src_r <= (in_tdata[2:0] == OP_DMA) ? {TopW{1'b0}} : mv_top_r;
          pj_src_r <= pj_top_r;
          case (in_tdata[2:0])
            OP_LOAD: staged_r[in_tdata[6:3]] <= {in_tdata[22:7], in_tdata[38:23]};
            OP_ADD: begin
              dst_pj_r <= in_tdata[39];
              if (in_tdata[39]) begin
                dst_r <= (in_tdata[40] && pj_top_r != TopW'(StackDepth-1))
                         ? pj_top_r + 1'b1 : pj_top_r;
                pj_top_r <= (in_tdata[40] && pj_top_r != TopW'(StackDepth-1))
                            ? pj_top_r + 1'b1 : pj_top_r;
              end else begin
                dst_r <= (in_tdata[40] && mv_top_r != TopW'(StackDepth-1))
                         ? mv_top_r + 1'b1 : mv_top_r;
                mv_top_r <= (in_tdata[40] && mv_top_r != TopW'(StackDepth-1))
                            ? mv_top_r + 1'b1 : mv_top_r;
              end
              phase_r <= 2'd0;
              if (in_tdata[41]) begin
                for (int i = 0; i < 16; i++) tmp_r[i] <= staged_r[i];
              end
            end
            OP_POP1: mv_top_r <= (mv_top_r != '0) ? mv_top_r - 1'b1 : mv_top_r;
            OP_POPN: begin
              if (in_tdata[84:53] != 32'd0 && {28'd0, mv_top_r} >= in_tdata[84:53])
                mv_top_r <= mv_top_r - in_tdata[53+TopW-1:53];
            end
            OP_DMA: begin
              mv_top_r <= in_tdata[45:42]; dst_r <= in_tdata[45:42];
              dst_pj_r <= 1'b0; phase_r <= 2'd0;
              if (!in_tdata[46]) begin
                for (int i = 0; i < 16; i++) tmp_r[i] <= staged_r[i];
              end
            end
            OP_RESET: begin
              mv_top_r <= '0; pj_top_r <= '0;
              dst_r <= '0; dst_pj_r <= 1'b0;
              for (int i = 0; i < 16; i++) tmp_r[i] <= ident(4'(i));
            end
            OP_INSERT: ;
            default: begin
              for (int i = 0; i < 16; i++) comb_r[i] <= staged_r[i];
            end
          endcase
        end
        S_MUL: kk_r <= kk_r + 3'd1;
        S_MULW: begin
          kk_r <= '0;
          if (phase_r == 2'd1) comb_r[ee_r] <= macs; else tmp_r[ee_r] <= macs;
          ee_r <= ee_r + 4'd1;
        end
        S_COPY: begin
          ee_r <= ee_r + 4'd1;
          if (ee_r == 4'd15 && c_op == OP_RESET && !dst_pj_r) dst_pj_r <= 1'b1;
        end
        S_IDW: ee_r <= ee_r + 4'd1;
        S_COMB: begin
          phase_r <= 2'd1; ee_r <= '0; kk_r <= '0;
          mv_src_r <= mv_top_r; pj_src_r <= pj_top_r;
        end
        S_INS: if (c_op == OP_INSERT && c_off[1:0] == 2'b00 && c_off <= 6'h3C) begin
          comb_r[c_off[4:1]] <= ins(comb_r[c_off[4:1]], c_arg[31:16], c_off[5]);
          comb_r[c_off[4:1] + 4'd1] <= ins(comb_r[c_off[4:1] + 4'd1], c_arg[15:0],
                                           c_off[5]);
        end
        S_EMIT: if (out_tready) emit_idx_r <= emit_idx_r + 4'd1;
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_EMIT);
  assign out_tdata  = {4'd0, emit_idx_r, comb_r[emit_idx_r]};
  assign out_tlast  = (emit_idx_r == 4'd15);

  `MSTE_ASSERT(a_busy_not_ready, state_r != S_IDLE, !in_tready, "ready while busy")
  `MSTE_ASSERT(a_last_idx, out_tvalid && out_tlast, emit_idx_r == 4'd15, "tlast misplaced")
  `MSTE_ASSERT_NEXT(a_emit_end, out_tvalid && out_tready && out_tlast,
                    state_r == S_IDLE, "emit did not end")
endmodule

### sim/testbench.sv
// Self-checking testbench for matrix_stack_transform_engine: drives matrix commands,
// predicts the combined-matrix words in fixed point and checks every output transaction.
// Depends on mste_pkg and the engine RTL.
module testbench;
  import mste_pkg::*;

  typedef struct packed {
    logic [31:0] arg_word;
    logic [5:0]  ins_off;
    logic        mul_first;
    logic [3:0]  stk_idx;
    logic        replace;
    logic        push;
    logic        to_proj;
    logic [15:0] elem_lo;
    logic [15:0] elem_hi;
    logic [3:0]  elem_idx;
    logic [2:0]  opcode;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;

  matrix_stack_transform_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] staged [16];
  logic signed [31:0] mv_stk [StackDepth][16];
  logic signed [31:0] pj_stk [StackDepth][16];
  logic signed [31:0] comb [16];
  int unsigned mv_top, pj_top;

  cmd_t  pending_cmds[$];
  word_t expected_words[$];
  int    errors = 0;
  int    cycles = 0;
  bit    hold_send = 1'b0;
  bit    stim_done = 1'b0;

  function automatic logic signed [31:0] unit_elem(int i);
    return (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
  endfunction

  function automatic longint fx_mul_round(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sh8000;
    return p >>> 16;
  endfunction

  // c = a * b with per-term rounding and saturation
  task automatic mat_product(input logic signed [31:0] a[16], input logic signed [31:0] b[16],
                             output logic signed [31:0] c[16]);
    longint s;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += fx_mul_round(a[i*4+k], b[k*4+j]);
        if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
        if (s < -64'sh8000_0000) s = -64'sh8000_0000;
        c[i*4+j] = s[31:0];
      end
  endtask

  task automatic refresh_combined();
    logic signed [31:0] a[16], b[16], c[16];
    a = mv_stk[mv_top];
    b = pj_stk[pj_top];
    mat_product(a, b, c);
    comb = c;
  endtask

  task automatic insert_halves(logic [5:0] off, logic [31:0] data);
    int base, e;
    logic [15:0] half;
    logic signed [31:0] v;
    logic [31:0] mag;
    longint ip, nv;
    if (off[1:0] != 0 || off > 6'h3C) return;
    base = (off < 6'h20) ? (off >> 1) : ((off - 6'h20) >> 1);
    for (int h = 0; h < 2; h++) begin
      half = (h == 0) ? data[31:16] : data[15:0];
      e = (base + h) & 15;
      v = comb[e];
      mag = (v < 0) ? (32'd0 - v) : v;
      if (off < 6'h20) begin
        nv = longint'($signed(half)) * 65536 + mag[15:0];
      end else begin
        ip = mag[31:16];
        if (v < 0) ip = -ip;
        nv = ip * 65536 + half;
        if (ip == 0 && v < 0) nv = -nv;
      end
      comb[e] = nv[31:0];
    end
  endtask

  // Apply one command to the prediction and queue its output words
  task automatic predict_cmd(cmd_t c);
    logic signed [31:0] old_m[16], res[16], st[16];
    int unsigned idx;
    if (c.opcode == OP_LOAD) begin
      staged[c.elem_idx] = {c.elem_hi, c.elem_lo};
      return;
    end
    st = staged;
    case (c.opcode)
      OP_ADD: begin
        if (c.to_proj) begin
          old_m = pj_stk[pj_top];
          if (c.push && pj_top < StackDepth - 1) pj_top++;
          if (c.replace) pj_stk[pj_top] = st;
          else begin mat_product(st, old_m, res); pj_stk[pj_top] = res; end
        end else begin
          old_m = mv_stk[mv_top];
          if (c.push && mv_top < StackDepth - 1) mv_top++;
          if (c.replace) mv_stk[mv_top] = st;
          else begin mat_product(st, old_m, res); mv_stk[mv_top] = res; end
        end
        refresh_combined();
      end
      OP_POP1: begin
        if (mv_top > 0) mv_top--;
        refresh_combined();
      end
      OP_POPN: begin
        if (c.arg_word != 0 && mv_top >= c.arg_word) mv_top -= c.arg_word;
        refresh_combined();
      end
      OP_DMA: begin
        idx = c.stk_idx;
        if (idx > StackDepth - 1) idx = StackDepth - 1;
        mv_top = idx;
        if (c.mul_first) begin
          old_m = mv_stk[0];
          mat_product(old_m, st, res);
          mv_stk[idx] = res;
        end else mv_stk[idx] = st;
        for (int i = 0; i < 16; i++) pj_stk[pj_top][i] = unit_elem(i);
        refresh_combined();
      end
      OP_RESET: begin
        for (int i = 0; i < 16; i++) begin
          mv_stk[0][i] = unit_elem(i);
          pj_stk[0][i] = unit_elem(i);
        end
        mv_top = 0;
        pj_top = 0;
        refresh_combined();
      end
      OP_INSERT: begin
        refresh_combined();
        insert_halves(c.ins_off, c.arg_word);
      end
      default: comb = st;
    endcase
    for (int k = 0; k < 16; k++) expected_words.push_back({comb[k], 4'(k), k == 15});
  endtask

  function automatic cmd_t rand_cmd(logic [2:0] op);
    cmd_t c;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    c = cmd_t'(rnd[84:0]);
    c.opcode = op;
    if ($urandom_range(0, 3) == 0) c.arg_word = $urandom_range(0, 17);
    return c;
  endfunction

  // Random staged word: mostly small values, sometimes any bits
  function automatic cmd_t load_cmd(int idx);
    cmd_t c;
    c = rand_cmd(OP_LOAD);
    c.elem_idx = 4'(idx);
    case ($urandom_range(0, 3))
      0: {c.elem_hi, c.elem_lo} = 32'h0001_0000;
      1: {c.elem_hi, c.elem_lo} = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: {c.elem_hi, c.elem_lo} = 32'd0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got v=%h i=%0d l=%0b want v=%h i=%0d l=%0b", what,
             got.value, got.index, got.last, want.value, want.index, want.last);
    errors++;
  endtask

  // Driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_cmds.pop_front());
        predict_cmd(cmd_t'(in_tdata[84:0]));
      end
      if ((in_tvalid && !in_tready) ) begin
        // hold item
      end else if (hold_send) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {3'd0, pending_cmds[0]};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end else burst_left <= burst_left - 1;
      end else in_tvalid <= 1'b0;
    end
  end

  // Receiver stall pattern and monitor
  logic [7:0] stall_pat = 8'b1011_0111;
  int stall_mode = 0;
  always @(posedge clk) begin
    word_t got, want;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[35:32], out_tlast};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected", got, got);
        end else begin
          want = expected_words.pop_front();
          if (got.value != want.value) report_mismatch("value", got, want);
          if (got.index != want.index) report_mismatch("index", got, want);
          if (got.last != want.last) report_mismatch("last", got, want);
        end
      end
      if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 2);
      stall_pat <= {stall_pat[6:0], stall_pat[7]};
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= stall_pat[0];
        default: out_tready <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_random_matrix();
    for (int i = 0; i < 16; i++) pending_cmds.push_back(load_cmd(i));
  endtask

  initial begin
    cmd_t c;
    int n;
    for (int i = 0; i < 16; i++) begin
      staged[i] = 32'sd0;
      comb[i] = unit_elem(i);
      for (int s = 0; s < StackDepth; s++) begin
        mv_stk[s][i] = (s == 0) ? unit_elem(i) : 32'sd0;
        pj_stk[s][i] = (s == 0) ? unit_elem(i) : 32'sd0;
      end
    end
    mv_top = 0;
    pj_top = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and every operation
    c = rand_cmd(OP_FORCE); pending_cmds.push_back(c);
    c = rand_cmd(OP_LOAD); c.elem_idx = 4'd0; {c.elem_hi, c.elem_lo} = 32'h7FFF_FFFF;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_LOAD); c.elem_idx = 4'd15; {c.elem_hi, c.elem_lo} = 32'h8000_0000;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_LOAD); c.elem_idx = 4'd5; {c.elem_hi, c.elem_lo} = 32'h7FFF_FFFF;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_FORCE); pending_cmds.push_back(c);
    c = rand_cmd(OP_ADD); c.to_proj = 1'b0; c.push = 1'b1; c.replace = 1'b0;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_ADD); c.to_proj = 1'b1; c.push = 1'b0; c.replace = 1'b0;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_POP1); pending_cmds.push_back(c);
    c = rand_cmd(OP_POP1); pending_cmds.push_back(c);
    c = rand_cmd(OP_DMA); c.stk_idx = 4'd15; c.mul_first = 1'b1; pending_cmds.push_back(c);
    c = rand_cmd(OP_POPN); c.arg_word = 32'd0; pending_cmds.push_back(c);
    c = rand_cmd(OP_POPN); c.arg_word = 32'd16; pending_cmds.push_back(c);
    c = rand_cmd(OP_POPN); c.arg_word = 32'd15; pending_cmds.push_back(c);
    c = rand_cmd(OP_INSERT); c.ins_off = 6'h3C; c.arg_word = 32'h8000_FFFF;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_INSERT); c.ins_off = 6'h00; c.arg_word = 32'hFFFF_8000;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_INSERT); c.ins_off = 6'h1E; pending_cmds.push_back(c);
    c = rand_cmd(OP_INSERT); c.ins_off = 6'h3F; pending_cmds.push_back(c);
    c = rand_cmd(OP_RESET); pending_cmds.push_back(c);
    // Push to a full stack: saturation case
    for (int i = 0; i < 17; i++) begin
      c = rand_cmd(OP_ADD); c.to_proj = 1'b1; c.push = 1'b1; c.replace = 1'b1;
      pending_cmds.push_back(c);
    end
    c = rand_cmd(OP_DMA); c.mul_first = 1'b0; pending_cmds.push_back(c);

    // Pause until every expected word has arrived
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    hold_send = 1'b1;
    wait (expected_words.size() == 0 && !in_tvalid);
    repeat (20) @(posedge clk);
    hold_send = 1'b0;

    // Random: mostly a full staged matrix followed by a command
    n = 0;
    while (n < 310) begin
      if ($urandom_range(0, 3) != 0) begin
        push_random_matrix();
        n += 16;
      end else begin
        pending_cmds.push_back(load_cmd($urandom_range(0, 15)));
        n++;
      end
      c = rand_cmd(3'($urandom_range(1, 7)));
      if (c.opcode == OP_INSERT && $urandom_range(0, 1)) c.ins_off[1:0] = 2'd0;
      pending_cmds.push_back(c);
      n++;
      while (pending_cmds.size() > 40) @(posedge clk);
    end

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (expected_words.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
